### rtl/tcp_pkg.sv
// ----------------------------------------------------------------------------
// tcp_pkg: throttle curve polynomial shared definitions
// Widths, fixed-point formats, coefficient ROM and the arithmetic helpers
// used by the Horner pipeline.
// ----------------------------------------------------------------------------
package tcp_pkg;

	localparam int FRAC_BITS   = 16;  // fraction bits of throttle and curve_out
	localparam int ACC_FRAC    = 30;  // fraction bits of the accumulator
	localparam int POLY_DEGREE = 10;  // default degree
	localparam int MAX_DEGREE  = 10;  // highest degree the ROM holds

	localparam int THR_W   = 17;      // throttle field
	localparam int OUT_W   = 18;      // curve_out field
	localparam int ACC_W   = 48;      // holds +/- 2^46
	localparam int SPLIT_W = 24;      // low partial of the accumulator
	localparam int HI_W    = ACC_W - SPLIT_W;
	localparam int PLO_W   = SPLIT_W + THR_W;       // unsigned low partial product
	localparam int PHI_W   = HI_W + THR_W + 1;      // signed high partial product
	localparam int PRD_W   = ACC_W + THR_W + 1;     // full signed product
	localparam int SUM_W   = PRD_W + 1;             // product after round and add

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [OUT_W-1:0] out_t;
	typedef logic        [THR_W-1:0] thr_t;
	typedef logic        [PLO_W-1:0] plo_t;
	typedef logic signed [PHI_W-1:0] phi_t;

	typedef enum logic {
		MODE_CRUISE = 1'b0,
		MODE_RACE   = 1'b1
	} curve_mode_t;

	localparam acc_t ACC_LIMIT = acc_t'(64'sd1 <<< 46);

	// Coefficient ROM, signed with ACC_FRAC fraction bits, constant term at 0.
	function automatic acc_t coef(input curve_mode_t mode, input int unsigned idx);
		acc_t c;
		c = '0;
		if (mode == MODE_RACE) begin
			case (idx)
				1:       c = 48'sd2105828994;
				2:       c = 48'sd1850278803;
				3:       c = -48'sd7183865069;
				4:       c = 48'sd4319985165;
				5:       c = 48'sd856066214;
				6:       c = -48'sd140641115;
				7:       c = 48'sd159976610;
				8:       c = -48'sd1356531662;
				9:       c = -48'sd50537769;
				10:      c = 48'sd537896670;
				default: c = '0;
			endcase
		end else begin
			case (idx)
				1:       c = 48'sd649085304;
				2:       c = 48'sd4091480748;
				3:       c = -48'sd7397490810;
				4:       c = 48'sd1658059194;
				5:       c = 48'sd1708568280;
				6:       c = -48'sd151752131;
				7:       c = 48'sd869096054;
				8:       c = -48'sd80056929;
				9:       c = -48'sd114413732;
				10:      c = -48'sd501755221;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

	// Join the partial products, round to ACC_FRAC, add the coefficient, saturate.
	function automatic acc_t horner_add(input phi_t phi, input plo_t plo, input acc_t c);
		logic signed [SUM_W-1:0] prod;
		logic signed [SUM_W-1:0] sum;
		prod = (SUM_W'(phi) <<< SPLIT_W) + SUM_W'($signed({1'b0, plo}));
		sum  = ((prod + (SUM_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS) + SUM_W'(c);
		if (sum > SUM_W'(ACC_LIMIT)) begin
			return ACC_LIMIT;
		end
		if (sum < -SUM_W'(ACC_LIMIT)) begin
			return -ACC_LIMIT;
		end
		return sum[ACC_W-1:0];
	endfunction

	// Round the accumulator to FRAC_BITS and saturate to +/- 2.0 and the field.
	function automatic out_t out_sat(input acc_t acc);
		localparam int   SH      = ACC_FRAC - FRAC_BITS;
		localparam acc_t RND     = acc_t'(64'sd1 <<< (SH - 1));
		localparam acc_t HI_TWO  = acc_t'((64'sd2 <<< FRAC_BITS) - 64'sd1);
		localparam acc_t LO_TWO  = -acc_t'(64'sd2 <<< FRAC_BITS);
		localparam acc_t HI_FLD  = acc_t'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
		localparam acc_t LO_FLD  = -acc_t'(64'sd1 <<< (OUT_W - 1));
		acc_t r;
		r = (acc + RND) >>> SH;
		if (r > HI_TWO) r = HI_TWO;
		if (r < LO_TWO) r = LO_TWO;
		if (r > HI_FLD) r = HI_FLD;
		if (r < LO_FLD) r = LO_FLD;
		return r[OUT_W-1:0];
	endfunction

endpackage

### rtl/throttle_curve_polynomial_core.sv
// ----------------------------------------------------------------------------
// throttle_curve_polynomial_core: pipelined throttle curve shaper
// Evaluates the cruise or race degree-N polynomial on a throttle fraction
// in Horner form and returns the rounded, saturated curve value.
// ----------------------------------------------------------------------------
//
//  channel   handshake                      payload
//  -------   ----------------------------   ---------------------------
//  request   throttle_valid / throttle_stall  throttle   [16:0] unsigned
//  result    curve_valid / curve_stall        curve_out  [17:0] signed
//  config    cfg_wr_en                        cfg_wr_data (curve_mode)
//
//  One request per cycle sustained while the skid slot is empty. With DEG the
//  clamped degree, the pipeline has one entry stage, then per Horner step one
//  multiply stage (two partial products of the accumulator) and one
//  round/add/saturate stage, then one output rounding stage.
//  Reset clears all valid bits, the skid slot and curve_mode (cruise).
//  A stalled result parks in a one-entry skid slot; only while that slot is
//  full does the whole pipeline freeze and throttle_stall rise.
// ----------------------------------------------------------------------------
module throttle_curve_polynomial_core #(
	parameter int POLY_DEGREE = tcp_pkg::POLY_DEGREE
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	input  logic                         throttle_valid,
	output logic                         throttle_stall,
	input  logic [tcp_pkg::THR_W-1:0]    throttle,
	output logic                         curve_valid,
	input  logic                         curve_stall,
	output logic signed [tcp_pkg::OUT_W-1:0] curve_out
);

	// Clamp the degree into the range the ROM covers.
	localparam int DEG = (POLY_DEGREE > tcp_pkg::MAX_DEGREE) ? tcp_pkg::MAX_DEGREE :
	                     ((POLY_DEGREE < 1) ? 1 : POLY_DEGREE);
	localparam int XM_N = (DEG > 1) ? DEG - 1 : 1;

	tcp_pkg::curve_mode_t curve_mode_q;

	// Accumulate stages: index 0 is the entry stage, index j+1 follows step j.
	logic                 vld_a_s  [0:DEG];
	tcp_pkg::acc_t        acc_a_s  [0:DEG];
	tcp_pkg::thr_t        x_a_s    [0:DEG-1];
	tcp_pkg::curve_mode_t mode_a_s [0:DEG-1];

	// Multiply stages, one per Horner step.
	logic                 vld_m_s  [0:DEG-1];
	tcp_pkg::plo_t        plo_m_s  [0:DEG-1];
	tcp_pkg::phi_t        phi_m_s  [0:DEG-1];
	tcp_pkg::curve_mode_t mode_m_s [0:DEG-1];
	tcp_pkg::thr_t        x_m_s    [0:XM_N-1];

	// Output stage and skid slot.
	logic          vld_o_s;
	tcp_pkg::out_t out_o_s;
	logic          skid_full_q;
	tcp_pkg::out_t skid_q;

	logic adv;
	logic take;

	// Advance the whole pipeline unless a stalled result is parked in the skid.
	assign adv            = !skid_full_q;
	assign throttle_stall = skid_full_q;
	assign take           = throttle_valid && !skid_full_q;

	assign curve_valid = skid_full_q || vld_o_s;
	assign curve_out   = skid_full_q ? skid_q : out_o_s;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= tcp_pkg::MODE_CRUISE;
		end else if (cfg_wr_en) begin
			curve_mode_q <= tcp_pkg::curve_mode_t'(cfg_wr_data);
		end
	end

	// Entry stage: latch the request and preload the top coefficient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_s[0] <= 1'b0;
		end else if (adv) begin
			vld_a_s[0] <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_a_s[0]    <= throttle;
			mode_a_s[0] <= curve_mode_q;
			acc_a_s[0]  <= tcp_pkg::coef(curve_mode_q, DEG);
		end
	end

	// Horner steps: coefficient index DEG-1-j at step j.
	for (genvar j = 0; j < DEG; j++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_m_s[j]   <= 1'b0;
				vld_a_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_m_s[j]   <= vld_a_s[j];
				vld_a_s[j+1] <= vld_m_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				plo_m_s[j]   <= tcp_pkg::PLO_W'(acc_a_s[j][tcp_pkg::SPLIT_W-1:0])
				              * tcp_pkg::PLO_W'(x_a_s[j]);
				phi_m_s[j]   <= tcp_pkg::PHI_W'($signed(acc_a_s[j][tcp_pkg::ACC_W-1:tcp_pkg::SPLIT_W]))
				              * tcp_pkg::PHI_W'($signed({1'b0, x_a_s[j]}));
				mode_m_s[j]  <= mode_a_s[j];
				acc_a_s[j+1] <= tcp_pkg::horner_add(phi_m_s[j], plo_m_s[j],
				                tcp_pkg::coef(mode_m_s[j], DEG - 1 - j));
			end
		end

		// Carry throttle and mode on to the next step.
		if (j + 1 < DEG) begin : g_fwd
			always_ff @(posedge clk) begin
				if (adv) begin
					x_m_s[j]       <= x_a_s[j];
					x_a_s[j+1]     <= x_m_s[j];
					mode_a_s[j+1]  <= mode_m_s[j];
				end
			end
		end
	end

	// Output stage: round to FRAC_BITS and saturate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_s <= 1'b0;
		end else if (adv) begin
			vld_o_s <= vld_a_s[DEG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_o_s <= tcp_pkg::out_sat(acc_a_s[DEG]);
		end
	end

	// Skid slot: catch the result when the consumer stalls, release on no stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			skid_full_q <= curve_stall;
		end else begin
			skid_full_q <= vld_o_s && curve_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_q <= out_o_s;
		end
	end

endmodule

### sim/tb_throttle_curve_polynomial_core.sv
// ----------------------------------------------------------------------------
// tb_throttle_curve_polynomial_core: self-checking bench for the curve shaper
// Streams throttle requests through the Horner pipeline in both curve modes,
// predicts each curve_out in 64-bit fixed point and checks results in order,
// with random gaps on the request side and random stall on the result side.
// ----------------------------------------------------------------------------
module tb_throttle_curve_polynomial_core;

	// Clamp the degree the same way the block does; latency follows from it.
	localparam int CURVE_DEG      = (tcp_pkg::POLY_DEGREE > tcp_pkg::MAX_DEGREE) ?
	                                tcp_pkg::MAX_DEGREE :
	                                (tcp_pkg::POLY_DEGREE < 1) ? 1 : tcp_pkg::POLY_DEGREE;
	localparam int PIPE_LATENCY   = 2 * CURVE_DEG + 2;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_ITEMS    = 120;

	localparam longint ACC_CAP   = 64'sd1 <<< 46;
	localparam longint STEP_HALF = 64'sd1 <<< (tcp_pkg::FRAC_BITS - 1);
	localparam int     OUT_SHIFT = tcp_pkg::ACC_FRAC - tcp_pkg::FRAC_BITS;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_wr_en      = 1'b0;
	logic                 cfg_wr_data    = 1'b0;
	logic                 throttle_valid = 1'b0;
	logic                 throttle_stall;
	tcp_pkg::thr_t        throttle       = '0;
	logic                 curve_valid;
	logic                 curve_stall    = 1'b0;
	tcp_pkg::out_t        curve_out;

	// Bench-side copy of the mode register, updated on the write edge.
	tcp_pkg::curve_mode_t curve_mode_q   = tcp_pkg::MODE_CRUISE;

	tcp_pkg::thr_t        throttle_backlog[$];   // requests not yet presented
	tcp_pkg::out_t        curve_expect[$];       // predicted curve_out, oldest first
	logic                 req_taken      = 1'b0; // request accepted at the last rising edge
	bit                   steady         = 1'b0; // suppress random gaps and stall
	int                   curve_errors   = 0;
	int                   quiet_cycles   = 0;

	wire req_fire   = throttle_valid && !throttle_stall;
	wire curve_fire = curve_valid && !curve_stall;

	throttle_curve_polynomial_core #(
		.POLY_DEGREE(tcp_pkg::POLY_DEGREE)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.throttle_valid(throttle_valid),
		.throttle_stall(throttle_stall),
		.throttle      (throttle),
		.curve_valid   (curve_valid),
		.curve_stall   (curve_stall),
		.curve_out     (curve_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Curve coefficients, constant term at k = 0, 30 fraction bits.
	function automatic longint curve_tap(input tcp_pkg::curve_mode_t mode, input int k);
		bit race;
		race = (mode == tcp_pkg::MODE_RACE);
		case (k)
			1:       return race ?  64'sd2105828994 :  64'sd649085304;
			2:       return race ?  64'sd1850278803 :  64'sd4091480748;
			3:       return race ? -64'sd7183865069 : -64'sd7397490810;
			4:       return race ?  64'sd4319985165 :  64'sd1658059194;
			5:       return race ?  64'sd856066214  :  64'sd1708568280;
			6:       return race ? -64'sd140641115  : -64'sd151752131;
			7:       return race ?  64'sd159976610  :  64'sd869096054;
			8:       return race ? -64'sd1356531662 : -64'sd80056929;
			9:       return race ? -64'sd50537769   : -64'sd114413732;
			10:      return race ?  64'sd537896670  : -64'sd501755221;
			default: return 64'sd0;
		endcase
	endfunction

	// Horner evaluation: each step rounds acc*x back to 30 fraction bits
	// (add half, floor), adds the next tap and clamps to +/- 65536.0. The
	// result is rounded half up to FRAC_BITS and clamped to +/- 2.0 and to
	// the 18-bit field. Products stay below 2^63 for any 17-bit throttle.
	function automatic tcp_pkg::out_t shape_curve(input tcp_pkg::curve_mode_t mode,
	                                              input tcp_pkg::thr_t x);
		longint xv;
		longint acc;
		longint r;
		longint hi_lim;
		longint lo_lim;
		xv  = x;
		acc = curve_tap(mode, CURVE_DEG);
		for (int k = CURVE_DEG - 1; k >= 0; k--) begin
			acc = ((acc * xv + STEP_HALF) >>> tcp_pkg::FRAC_BITS) + curve_tap(mode, k);
			if (acc > ACC_CAP) acc = ACC_CAP;
			if (acc < -ACC_CAP) acc = -ACC_CAP;
		end
		r      = (acc + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
		hi_lim = (64'sd2 <<< tcp_pkg::FRAC_BITS) - 1;
		lo_lim = -(64'sd2 <<< tcp_pkg::FRAC_BITS);
		if (r > hi_lim) r = hi_lim;
		if (r < lo_lim) r = lo_lim;
		if (r > (64'sd1 <<< (tcp_pkg::OUT_W - 1)) - 1) r = (64'sd1 <<< (tcp_pkg::OUT_W - 1)) - 1;
		if (r < -(64'sd1 <<< (tcp_pkg::OUT_W - 1))) r = -(64'sd1 <<< (tcp_pkg::OUT_W - 1));
		return tcp_pkg::out_t'(r);
	endfunction

	// ------------------------------------------------------------------
	// Request driver: present the next backlog entry at the falling edge,
	// hold it until accepted, and insert random gaps unless steady.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!throttle_valid || req_taken)) begin
			if (throttle_backlog.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
				throttle_valid <= 1'b1;
				throttle       <= throttle_backlog.pop_front();
			end else begin
				throttle_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure: stall at random, about 30 percent of the time.
	always @(negedge clk) begin
		curve_stall <= arst_n && !steady && ($urandom_range(99) < 30);
	end

	// ------------------------------------------------------------------
	// Monitor: track the mode register, predict on each accepted request,
	// check each accepted result against the oldest prediction, and count
	// cycles with no progress for the watchdog.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		tcp_pkg::out_t want;
		req_taken <= arst_n && req_fire;
		if (arst_n) begin
			if (cfg_wr_en) begin
				curve_mode_q <= tcp_pkg::curve_mode_t'(cfg_wr_data);
			end
			if (req_fire) begin
				curve_expect.push_back(shape_curve(curve_mode_q, throttle));
			end
			if (curve_fire) begin
				if (curve_expect.size() == 0) begin
					$error("curve_out: no request outstanding, got %0d", curve_out);
					curve_errors++;
				end else begin
					want = curve_expect.pop_front();
					if (curve_out !== want) begin
						$error("curve_out: expected %0d, got %0d", want, curve_out);
						curve_errors++;
					end
				end
			end
			// Drop the run if nothing moves for too long.
			if (req_fire || curve_fire) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("throttle_curve_polynomial_core verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Mostly in-range fractions, some near 0 and 1.0, the rest over the
	// whole 17-bit field so the saturating region above 1.0 is exercised.
	function automatic tcp_pkg::thr_t random_throttle();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60) begin
			return tcp_pkg::thr_t'($urandom_range(65536));
		end else if (pick < 75) begin
			return $urandom_range(1) ? tcp_pkg::thr_t'($urandom_range(255))
			                         : tcp_pkg::thr_t'(65536 - $urandom_range(255));
		end
		return tcp_pkg::thr_t'($urandom_range(131071));
	endfunction

	// Hold until every request has gone through and every result is back.
	task automatic wait_idle();
		do @(negedge clk);
		while (throttle_backlog.size() != 0 || throttle_valid || curve_expect.size() != 0);
	endtask

	// Write the mode register for one cycle; only called while idle.
	task automatic write_curve_mode(input tcp_pkg::curve_mode_t mode);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		tcp_pkg::thr_t corners[12];
		corners = '{
			17'd0, 17'd1, 17'd16384, 17'd32768, 17'd49152, 17'd65535,
			17'd65536, 17'd65537, 17'd98304, 17'h0AAAA, 17'h15555, 17'h1FFFF
		};

		// Hold reset, then release it on a falling edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Corners in the reset mode (cruise), then again in race.
		foreach (corners[i]) throttle_backlog.push_back(corners[i]);
		wait_idle();
		write_curve_mode(tcp_pkg::MODE_RACE);
		foreach (corners[i]) throttle_backlog.push_back(corners[i]);
		wait_idle();

		// Random phases, alternating modes; one phase runs without gaps.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_curve_mode((ph % 2 == 0) ? tcp_pkg::MODE_CRUISE : tcp_pkg::MODE_RACE);
			steady = (ph == 2);
			repeat (PHASE_ITEMS) throttle_backlog.push_back(random_throttle());
			wait_idle();
		end
		steady = 1'b0;

		// Let any stray result show up before the verdict.
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (curve_errors == 0 && curve_expect.size() == 0) begin
			$display("throttle_curve_polynomial_core verification clean");
		end else begin
			$display("throttle_curve_polynomial_core verification failed");
		end
		$finish;
	end

endmodule
